// ===== src/opsm_pkg.sv =====
// Shared constants and types for the ordered pool successor match unit.
package opsm_pkg;

  localparam int unsigned POOL_DEPTH = 1024;
  localparam int unsigned VAL_W      = 31;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned TAP_W      = VAL_W + 1;

  // Reduction tree grouping
  localparam int unsigned GRP_W = 32;
  localparam int unsigned NG1   = (POOL_DEPTH + GRP_W - 1) / GRP_W;
  localparam int unsigned NG2   = (NG1 + GRP_W - 1) / GRP_W;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Contents of one pool cell
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } cell_st_t;

  // Operation broadcast to all cells in the accept cycle
  typedef struct packed {
    logic             ins;
    logic             mat;
    logic             clr;
    logic [VAL_W-1:0] value;
  } cell_op_t;

endpackage

// ===== src/opsm_cell.sv =====
// One pool cell: holds one slot of the sorted pool and shifts with its neighbors.
module opsm_cell
  import opsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_op_t         op_i,
  input  cell_st_t         left_i,
  input  logic             left_flag_i,
  input  cell_st_t         right_i,
  output cell_st_t         st_o,
  output logic             flag_o,
  output logic [TAP_W-1:0] tap_o
);

  logic             valid_q, valid_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             flag;

  // Empty slots count as +infinity, so the flag is monotone along the row.
  assign flag = !valid_q || (value_q > op_i.value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (op_i.clr) begin
      valid_d = 1'b0;
    end else if (op_i.ins) begin
      if (left_flag_i) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else if (flag) begin
        valid_d = 1'b1;
        value_d = op_i.value;
      end
    end else if (op_i.mat) begin
      if (flag) begin
        valid_d = right_i.valid;
        value_d = right_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign st_o   = '{valid: valid_q, value: value_q};
  assign flag_o = flag;
  // Only the first cell above the query reports, and only if it holds a value.
  assign tap_o  = (op_i.mat && flag && !left_flag_i && valid_q) ? {1'b1, value_q}
                                                                 : '0;

endmodule

// ===== src/opsm_or_tree.sv =====
// Registered OR reduction of the per-cell match taps.
module opsm_or_tree
  import opsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TAP_W-1:0] taps_i [POOL_DEPTH],
  output logic             res_valid_o,
  output logic [TAP_W-1:0] res_o
);

  logic [TAP_W-1:0] l1_q [NG1];
  logic [TAP_W-1:0] l1_d [NG1];
  logic [TAP_W-1:0] l2_q [NG2];
  logic [TAP_W-1:0] l2_d [NG2];
  logic             v1_q, v2_q;

  for (genvar g = 0; g < NG1; g++) begin : g_l1
    always_comb begin
      l1_d[g] = '0;
      for (int k = 0; k < GRP_W; k++) begin
        if (g * GRP_W + k < POOL_DEPTH) begin
          l1_d[g] = l1_d[g] | taps_i[g * GRP_W + k];
        end
      end
    end
  end

  for (genvar g = 0; g < NG2; g++) begin : g_l2
    always_comb begin
      l2_d[g] = '0;
      for (int k = 0; k < GRP_W; k++) begin
        if (g * GRP_W + k < NG1) begin
          l2_d[g] = l2_d[g] | l1_q[g * GRP_W + k];
        end
      end
    end
  end

  always_comb begin
    res_o = '0;
    for (int k = 0; k < NG2; k++) begin
      res_o = res_o | l2_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      l1_q <= l1_d;
    end
    if (v1_q) begin
      l2_q <= l2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  assign res_valid_o = v2_q;

endmodule

// ===== src/ordered_pool_successor_match_unit.sv =====
// Top level: sorted pool held in a row of cells, with result reduction and output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | kind_i, value_i
//   out     | output    | out_valid_o / out_ready_i| status_o, found_o, matched_value_o,
//           |           |                          | match_count_o
//
// Each item moves in order: the pool updates and the first registered level of the
// tap OR tree captures the taps at the accept edge, then the second level, then the
// output register takes the removed value; no new item is taken before then.
// Reset empties every cell and zeroes the match counter at once; no sweep.
// A stalled result holds the block: an item is taken only when the output
// register is empty or being emptied in the same cycle.
module ordered_pool_successor_match_unit
  import opsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic              found_o,
  output logic [VAL_W-1:0]  matched_value_o,
  output logic [CNT_W-1:0]  match_count_o
);

  cell_st_t          cell_st   [POOL_DEPTH];
  logic              cell_flag [POOL_DEPTH];
  logic [TAP_W-1:0]  cell_tap  [POOL_DEPTH];
  cell_op_t          op;

  logic              acc;
  logic              full;
  logic              busy_q;
  logic [KIND_W-1:0] kind_q;
  logic              status_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              res_valid;
  logic [TAP_W-1:0]  res;

  logic              out_valid_q;
  logic              out_status_q;
  logic              out_found_q;
  logic [VAL_W-1:0]  out_value_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // Pool is kept sorted ascending with valid cells packed at the low end,
  // so the last cell being valid means the pool is full.
  assign full       = cell_st[POOL_DEPTH-1].valid;
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;

  assign op.ins   = acc && (kind_i == KIND_INSERT) && !full;
  assign op.mat   = acc && (kind_i == KIND_MATCH);
  assign op.clr   = acc && (kind_i == KIND_CLEAR);
  assign op.value = value_i;

  // Row of cells: inserts shift right from the left neighbor, removals pull
  // from the right neighbor.
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    cell_st_t left_st, right_st;
    logic     left_flag;

    if (i == 0) begin : g_first
      assign left_st   = '0;
      assign left_flag = 1'b0;
    end else begin : g_mid
      assign left_st   = cell_st[i-1];
      assign left_flag = cell_flag[i-1];
    end

    if (i == POOL_DEPTH - 1) begin : g_last
      assign right_st = '0;
    end else begin : g_inner
      assign right_st = cell_st[i+1];
    end

    opsm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .left_i      (left_st),
      .left_flag_i (left_flag),
      .right_i     (right_st),
      .st_o        (cell_st[i]),
      .flag_o      (cell_flag[i]),
      .tap_o       (cell_tap[i])
    );
  end

  // Gathers the removed value; carries every item, taps are zero except on a match.
  opsm_or_tree u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (acc),
    .taps_i      (cell_tap),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_q   <= kind_i;
      status_q <= (kind_i == KIND_INSERT) && full;
    end
  end

  // Counter settles when the result comes out of the tree.
  always_comb begin
    cnt_d = cnt_q;
    if (kind_q == KIND_CLEAR) begin
      cnt_d = '0;
    end else if ((kind_q == KIND_MATCH) && res[TAP_W-1] && (cnt_q != CNT_MAX)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        busy_q <= 1'b1;
      end else if (res_valid) begin
        busy_q <= 1'b0;
      end
      if (res_valid) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_status_q <= status_q;
      out_found_q  <= res[TAP_W-1];
      out_value_q  <= res[VAL_W-1:0];
      out_cnt_q    <= cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign found_o         = out_found_q;
  assign matched_value_o = out_value_q;
  assign match_count_o   = out_cnt_q;

endmodule

// ===== dv/opsm_successor_checker.sv =====
// Checker for the successor match unit: predicts each result from the item stream and compares.
module opsm_successor_checker
  import opsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              status_i,
  input  logic              found_i,
  input  logic [VAL_W-1:0]  matched_value_i,
  input  logic [CNT_W-1:0]  match_count_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       outstanding_o,
  output int unsigned       results_o,
  output int unsigned       hits_o,
  output int unsigned       refusals_o,
  output logic              saturated_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [VAL_W-1:0] mval;
    logic [CNT_W-1:0] count;
  } match_result_t;

  // Pool contents as a plain multiset; slot positions do not affect results.
  logic [VAL_W-1:0] pool_model[$];
  logic [CNT_W-1:0] match_tally;
  match_result_t    awaited_q[$];

  function automatic match_result_t apply_pool_item(input logic [KIND_W-1:0] kind,
                                                    input logic [VAL_W-1:0]  val);
    match_result_t r;
    int            best;
    r    = '0;
    best = -1;
    case (kind)
      KIND_INSERT: begin
        if (pool_model.size() >= POOL_DEPTH) r.status = 1'b1;
        else pool_model.push_back(val);
      end
      KIND_MATCH: begin
        foreach (pool_model[i]) begin
          if (pool_model[i] > val && (best < 0 || pool_model[i] < pool_model[best])) best = i;
        end
        if (best >= 0) begin
          r.found = 1'b1;
          r.mval  = pool_model[best];
          pool_model.delete(best);
          if (match_tally != CNT_MAX) match_tally++;
        end
      end
      KIND_CLEAR: begin
        pool_model.delete();
        match_tally = '0;
      end
      default: ;  // unused kind leaves everything alone
    endcase
    r.count = match_tally;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_result_t want;
    if (!rst_ni) begin
      pool_model.delete();
      awaited_q.delete();
      match_tally    = '0;
      mismatch_cnt_o = 0;
      outstanding_o  = 0;
      results_o      = 0;
      hits_o         = 0;
      refusals_o     = 0;
      saturated_o    = 1'b0;
    end else begin
      // Result side first: a result leaving now always belongs to an older item.
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (awaited_q.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("[%0t] result with no item pending: status=%0b found=%0b value=%h count=%0d",
                     $realtime, status_i, found_i, matched_value_i, match_count_i);
          mismatch_cnt_o++;
        end else begin
          want = awaited_q.pop_front();
          if (status_i !== want.status || found_i !== want.found ||
              matched_value_i !== want.mval || match_count_i !== want.count) begin
            if (mismatch_cnt_o < 10)
              $display("[%0t] mismatch: want status=%0b found=%0b value=%h count=%0d, got %0b %0b %h %0d",
                       $realtime, want.status, want.found, want.mval, want.count,
                       status_i, found_i, matched_value_i, match_count_i);
            mismatch_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_pool_item(kind_i, value_i);
        if (want.found) hits_o++;
        if (want.status) refusals_o++;
        if (want.count == CNT_MAX) saturated_o = 1'b1;
        awaited_q.push_back(want);
      end
      outstanding_o = awaited_q.size();
    end
  end

endmodule

// ===== dv/ordered_pool_successor_match_unit_tb.sv =====
// Testbench top for the successor match unit: clock, reset, item stimulus and verdict.
module ordered_pool_successor_match_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import opsm_pkg::*;

  // Kind 3 has no name in the package; the block must ignore it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0]  VAL_MAX     = {VAL_W{1'b1}};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [KIND_W-1:0] kind_i      = '0;
  logic [VAL_W-1:0]  value_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              status_o;
  logic              found_o;
  logic [VAL_W-1:0]  matched_value_o;
  logic [CNT_W-1:0]  match_count_o;

  int unsigned mismatch_cnt;
  int unsigned outstanding;
  int unsigned result_cnt;
  int unsigned hit_cnt;
  int unsigned refusal_cnt;
  logic        saturated;

  // Idle percentages per channel; changed between phases.
  int unsigned src_idle_pct  = 27;
  int unsigned sink_idle_pct = 85;

  ordered_pool_successor_match_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .matched_value_o(matched_value_o),
    .match_count_o  (match_count_o)
  );

  opsm_successor_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .found_i        (found_o),
    .matched_value_i(matched_value_o),
    .match_count_i  (match_count_o),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding),
    .results_o      (result_cnt),
    .hits_o         (hit_cnt),
    .refusals_o     (refusal_cnt),
    .saturated_o    (saturated)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: one ready decision per falling edge, stalls at the phase's rate.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Present one item, starting at a falling edge, and hold it until taken.
  // Valid is only lowered when an idle cycle is actually inserted, so a
  // back-to-back item never sees valid dropped and raised in one step.
  task automatic offer_item(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Values: a narrow band near zero so inserts and queries collide, plus the
  // top of the range, the two extremes and full-width random patterns.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1:       return VAL_MAX;
      2, 3:    return VAL_MAX - VAL_W'($urandom_range(15));
      4, 5, 6: return VAL_W'($urandom_range(63));
      default: return raw[VAL_W-1:0];
    endcase
  endfunction

  // Random traffic: inserts and matches dominate so the pool stays populated;
  // clears and the unused kind show up now and then.
  task automatic random_traffic(input int unsigned n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 48)      offer_item(KIND_INSERT, pick_value());
      else if (roll < 95) offer_item(KIND_MATCH, pick_value());
      else if (roll < 98) offer_item(KIND_CLEAR, pick_value());
      else                offer_item(KIND_UNUSED, pick_value());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- Phase 1: sender idles lightly, receiver stalls hard ----
    // Directed: empty-pool miss, extremes, duplicates, strict-greater rule,
    // top-value miss, unused kind, clear.
    offer_item(KIND_MATCH,  '0);                 // empty pool, not found
    offer_item(KIND_INSERT, '0);
    offer_item(KIND_INSERT, VAL_MAX);
    offer_item(KIND_INSERT, 31'h2AAA_AAAA);
    offer_item(KIND_INSERT, 31'h5555_5555);
    offer_item(KIND_INSERT, 31'd5);
    offer_item(KIND_INSERT, 31'd5);              // duplicate
    offer_item(KIND_MATCH,  VAL_MAX);            // nothing above max
    offer_item(KIND_MATCH,  '0);                 // takes one 5
    offer_item(KIND_MATCH,  31'd4);              // takes the other 5
    offer_item(KIND_MATCH,  31'd5);              // equal is not a successor
    offer_item(KIND_MATCH,  VAL_MAX - 1'b1);     // takes max
    offer_item(KIND_MATCH,  '0);                 // 0 itself never matches 0
    offer_item(KIND_MATCH,  '0);                 // only 0 left, not found
    offer_item(KIND_UNUSED, VAL_MAX);            // ignored
    offer_item(KIND_UNUSED, '0);
    offer_item(KIND_CLEAR,  VAL_MAX);            // all-zero result
    offer_item(KIND_MATCH,  '0);                 // pool empty after clear
    offer_item(KIND_INSERT, 31'h1234_5678);
    offer_item(KIND_MATCH,  31'h1234_5677);
    random_traffic(140);

    // ---- Phase 2: roles swapped ----
    src_idle_pct  = 85;
    sink_idle_pct = 27;
    random_traffic(140);

    // ---- Phase 3: no idling on either side ----
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_traffic(140);

    // Fill the pool to the brim, then knock on it while full.
    offer_item(KIND_CLEAR, '0);
    repeat (POOL_DEPTH) offer_item(KIND_INSERT, pick_value());
    offer_item(KIND_INSERT, VAL_MAX);            // refused
    offer_item(KIND_INSERT, '0);                 // refused
    offer_item(KIND_MATCH,  VAL_MAX);            // miss, pool still full
    offer_item(KIND_INSERT, 31'd7);              // still refused
    offer_item(KIND_MATCH,  '0);                 // frees a slot unless all zero
    offer_item(KIND_INSERT, VAL_MAX);
    offer_item(KIND_INSERT, 31'd9);              // full again
    random_traffic(60);
    offer_item(KIND_CLEAR, '0);

    offer_item(KIND_MATCH,  '0);                 // miss on an empty pool
    offer_item(KIND_UNUSED, 31'h4000_0001);      // reports the held count
    offer_item(KIND_CLEAR,  '0);
    offer_item(KIND_INSERT, 31'd3);
    offer_item(KIND_MATCH,  31'd2);              // counter restarts at one

    in_valid_i <= 1'b0;

    // Drain: wait for every expected result, then let the block settle.
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d results: %0d successor hits, %0d full-pool refusals.",
             result_cnt, hit_cnt, refusal_cnt);
    $display("Match counter saturation %s; idle mixes 27/85, 85/27 and none.",
             saturated ? "reached" : "not reached");
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/opsm_pkg.sv
src/opsm_cell.sv
src/opsm_or_tree.sv
src/ordered_pool_successor_match_unit.sv
dv/opsm_successor_checker.sv
dv/ordered_pool_successor_match_unit_tb.sv
